### rtl/chm_pkg.sv
// Package for the chained hash map: sizes, pointer type, opcodes, status
// codes and the sequencer state encoding. No dependencies.
package chm_pkg;

  localparam int BUCKET_BITS    = 10;
  localparam int NUM_BUCKETS    = 1 << BUCKET_BITS;
  localparam int ENTRY_CAPACITY = 1024;
  localparam int IDX_W          = $clog2(ENTRY_CAPACITY);
  localparam int COUNT_W        = $clog2(ENTRY_CAPACITY + 1);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Chain link: valid flag plus entry index.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } ptr_t;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_HEAD   = 7'b0000100,
    ST_WALK   = 7'b0001000,
    ST_UPDATE = 7'b0010000,
    ST_LINK   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

endpackage

### rtl/chained_hash_map_int.sv
// Chained hash map, 32-bit keys to 32-bit values, separate chaining.
// Depends on chm_pkg; holds the bucket head and entry memories.
//
// Usage:
//   Requests come in on in_valid_i/in_ready_o with opcode_i (get or put),
//   key_i and new_value_i. Each request gives one result on
//   out_valid_o/out_ready_i: value_out_o, key_found_o and status_o.
//   The bucket is the low key bits; a get walks the chain, a put replaces
//   a present value or appends a new entry, or reports table full.
//   cfg_wdata_i is written to the null value when cfg_we_i is high.
// Timing:
//   One request at a time; the block returns to idle, ready for the next
//   request, when the result is registered. The chain walk reads one entry
//   per cycle.
// Reset:
//   After reset a clearing pass writes all 1024 bucket heads empty, one per
//   cycle; in_ready_o stays low until the pass ends.
// Stall:
//   A finished result waits in the output register. The next request is
//   accepted meanwhile; its own result holds until the output is taken.
module chained_hash_map_int (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic signed [31:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic signed [31:0]  key_i,
  input  logic signed [31:0]  new_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  value_out_o,
  output logic                key_found_o,
  output logic                status_o
);
  import chm_pkg::*;

  state_e state_q, state_d;

  logic signed [31:0]     null_q;
  logic                   op_q;
  logic [31:0]            key_q;
  logic [31:0]            val_q;
  logic [BUCKET_BITS-1:0] clr_cnt_q;
  logic [COUNT_W-1:0]     cnt_q;
  logic [IDX_W-1:0]       cur_q, last_q;
  logic                   have_last_q;
  logic [31:0]            res_value_q;
  logic                   res_found_q;
  logic                   res_status_q;
  logic                   out_valid_q;
  logic [31:0]            out_value_q;
  logic                   out_found_q;
  logic                   out_status_q;

  // Memories
  ptr_t        head_mem [NUM_BUCKETS];
  logic [31:0] key_mem  [ENTRY_CAPACITY];
  logic [31:0] val_mem  [ENTRY_CAPACITY];
  ptr_t        next_mem [ENTRY_CAPACITY];

  ptr_t        head_rd_q;
  logic [31:0] key_rd_q;
  logic [31:0] val_rd_q;
  ptr_t        next_rd_q;

  logic                   head_we;
  logic [BUCKET_BITS-1:0] head_waddr;
  ptr_t                   head_wdata;
  logic                   entry_we;
  logic                   val_we;
  logic [IDX_W-1:0]       val_waddr;
  logic                   next_we;
  logic [IDX_W-1:0]       next_waddr;
  ptr_t                   next_wdata;
  logic [IDX_W-1:0]       entry_raddr;

  logic                   accept;
  logic                   out_free;
  logic                   table_full;
  logic                   key_hit;
  logic [IDX_W-1:0]       new_idx;
  logic [BUCKET_BITS-1:0] bucket;

  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign table_full = (cnt_q == COUNT_W'(ENTRY_CAPACITY));
  assign key_hit    = (key_rd_q == key_q);
  assign new_idx    = cnt_q[IDX_W-1:0];
  assign bucket     = key_q[BUCKET_BITS-1:0];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_out_o = out_value_q;
  assign key_found_o = out_found_q;
  assign status_o    = out_status_q;

  // Entry read: head pointer right after the head read, next link in the walk.
  assign entry_raddr = (state_q == ST_HEAD) ? head_rd_q.idx : next_rd_q.idx;

  always_comb begin
    state_d    = state_q;
    head_we    = 1'b0;
    head_waddr = clr_cnt_q;
    head_wdata = '0;
    entry_we   = 1'b0;
    val_we     = 1'b0;
    val_waddr  = new_idx;
    next_we    = 1'b0;
    next_waddr = new_idx;
    next_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        head_we = 1'b1;
        if (clr_cnt_q == BUCKET_BITS'(NUM_BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (head_rd_q.valid) begin
          state_d = ST_WALK;
        end else if (op_q == OP_PUT && !table_full) begin
          state_d = ST_UPDATE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WALK: begin
        if (key_hit) begin
          state_d = (op_q == OP_PUT) ? ST_UPDATE : ST_DONE;
        end else if (!next_rd_q.valid) begin
          state_d = (op_q == OP_PUT && !table_full) ? ST_UPDATE : ST_DONE;
        end
      end
      ST_UPDATE: begin
        val_we = 1'b1;
        if (res_found_q) begin
          val_waddr = cur_q;
          state_d   = ST_DONE;
        end else begin
          entry_we = 1'b1;
          next_we  = 1'b1;
          state_d  = ST_LINK;
        end
      end
      ST_LINK: begin
        if (have_last_q) begin
          next_we    = 1'b1;
          next_waddr = last_q;
          next_wdata = '{valid: 1'b1, idx: new_idx};
        end else begin
          head_we    = 1'b1;
          head_waddr = bucket;
          head_wdata = '{valid: 1'b1, idx: new_idx};
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      cnt_q        <= '0;
      null_q       <= '0;
      out_valid_q  <= 1'b0;
      have_last_q  <= 1'b0;
      res_found_q  <= 1'b0;
      res_status_q <= STATUS_OK;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        null_q <= cfg_wdata_i;
      end
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (accept) begin
        have_last_q <= 1'b0;
        res_found_q <= 1'b0;
      end
      if (state_q == ST_WALK) begin
        if (key_hit) begin
          res_found_q <= 1'b1;
        end else begin
          have_last_q <= 1'b1;
        end
      end
      if ((state_q == ST_HEAD && !head_rd_q.valid) ||
          (state_q == ST_WALK && !key_hit && !next_rd_q.valid)) begin
        res_status_q <= (op_q == OP_PUT && table_full) ? STATUS_FULL : STATUS_OK;
      end else if (state_q == ST_WALK && key_hit) begin
        res_status_q <= STATUS_OK;
      end
      if (state_q == ST_LINK) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= opcode_i;
      key_q       <= key_i;
      val_q       <= new_value_i;
      res_value_q <= null_q;
    end
    if (state_q == ST_HEAD) begin
      cur_q <= head_rd_q.idx;
    end
    if (state_q == ST_WALK) begin
      if (key_hit) begin
        res_value_q <= val_rd_q;
      end else begin
        last_q <= cur_q;
        cur_q  <= next_rd_q.idx;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_value_q  <= res_value_q;
      out_found_q  <= res_found_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_q <= head_mem[key_i[BUCKET_BITS-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      key_mem[new_idx] <= key_q;
    end
    key_rd_q <= key_mem[entry_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_q;
    end
    val_rd_q <= val_mem[entry_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_q <= next_mem[entry_raddr];
  end

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= COUNT_W'(ENTRY_CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == STATUS_FULL |-> !out_found_q)
    else $error("table full reported for a present key");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + 1'b1 && $past(state_q) == ST_LINK)
    else $error("entry count moved outside a link step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE |-> op_q == OP_PUT && (res_found_q || !table_full))
    else $error("memory update without a storable put");

endmodule

### tb/chained_hash_map_int_test.sv
// Self-checking bench for chained_hash_map_int: get/put requests under varied idling,
// predicted by a shadow copy of the chained table. Depends on chm_pkg and the RTL only.
module chained_hash_map_int_test;
  import chm_pkg::*;

  localparam int unsigned STALL_LIMIT = 10000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PRINT_CAP = 200;
  localparam int unsigned PHASE_ITEMS = 450;

  typedef struct packed {
    logic [31:0] value;
    logic        found;
    logic        status;
  } map_reply_t;

  // Shadow of the map: bucket heads, entry pool and the replies still owed.
  class hash_map_shadow;
    ptr_t        bucket_head [NUM_BUCKETS];
    logic [31:0] entry_key   [ENTRY_CAPACITY];
    logic [31:0] entry_val   [ENTRY_CAPACITY];
    ptr_t        entry_link  [ENTRY_CAPACITY];
    int unsigned used_entries;
    logic [31:0] null_value;
    map_reply_t  pending_replies [$];
    int unsigned mismatches;

    function new();
      foreach (bucket_head[i]) bucket_head[i] = '0;
      used_entries = 0;
      null_value = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(input string what);
      if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void note_request(input logic op, input logic [31:0] key,
                               input logic [31:0] val);
      map_reply_t reply;
      logic [BUCKET_BITS-1:0] bkt;
      ptr_t cur;
      ptr_t tail;
      bit hit;
      bkt = key[BUCKET_BITS-1:0];
      reply = '{value: null_value, found: 1'b0, status: STATUS_OK};
      hit = 1'b0;
      tail = '0;
      cur = bucket_head[bkt];
      while (cur.valid && !hit) begin
        if (entry_key[cur.idx] == key) begin
          hit = 1'b1;
        end else begin
          tail = cur;
          cur = entry_link[cur.idx];
        end
      end
      if (hit) begin
        reply.value = entry_val[cur.idx];
        reply.found = 1'b1;
        if (op == OP_PUT) entry_val[cur.idx] = val;
      end else if (op == OP_PUT) begin
        if (used_entries >= ENTRY_CAPACITY) begin
          reply.status = STATUS_FULL;
        end else begin
          entry_key[used_entries] = key;
          entry_val[used_entries] = val;
          entry_link[used_entries] = '0;
          // append at the chain end, or start the chain
          if (tail.valid) entry_link[tail.idx] = '{valid: 1'b1, idx: IDX_W'(used_entries)};
          else bucket_head[bkt] = '{valid: 1'b1, idx: IDX_W'(used_entries)};
          used_entries++;
        end
      end
      pending_replies.push_back(reply);
    endfunction

    task check_result(input logic [31:0] value, input logic found, input logic status);
      map_reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply value=%h found=%b status=%b",
                                  value, found, status));
      end else begin
        want = pending_replies.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("value_out %h, want %h", value, want.value));
        if (found !== want.found)
          report_mismatch($sformatf("key_found %b, want %b", found, want.found));
        if (status !== want.status)
          report_mismatch($sformatf("status %b, want %b", status, want.status));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic signed [31:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               opcode_i;
  logic signed [31:0] key_i;
  logic signed [31:0] new_value_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] value_out_o;
  logic               key_found_o;
  logic               status_o;

  hash_map_shadow shadow = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles = 0;
  logic [BUCKET_BITS-1:0] hot_buckets [6] = '{10'd0, 10'd1023, 10'd512, 10'd5, 10'd300,
                                             10'd777};

  chained_hash_map_int i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .new_value_i (new_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_out_o (value_out_o),
    .key_found_o (key_found_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      shadow.check_result(value_out_o, key_found_o, status_o);
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic op, input logic [31:0] key,
                              input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    opcode_i    <= op;
    key_i       <= key;
    new_value_i <= val;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.note_request(op, key, val);
    @(negedge clk_i);
  endtask

  task automatic set_null_value(input logic [31:0] val);
    in_valid_i <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    shadow.null_value = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] hot_key();
    logic [31:0] k;
    k = $urandom();
    k[BUCKET_BITS-1:0] = hot_buckets[$urandom_range(5)];
    return k;
  endfunction

  function automatic logic [31:0] stored_key();
    return shadow.entry_key[$urandom_range(shadow.used_entries - 1)];
  endfunction

  // Mostly new-key puts so the pool fills and the full case is hit late in the run.
  task automatic send_random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65)
      send_request(OP_PUT, ($urandom_range(99) < 30) ? hot_key() : $urandom(), $urandom());
    else if (pick < 75)
      send_request(OP_PUT, stored_key(), $urandom());
    else if (pick < 87)
      send_request(OP_GET, stored_key(), $urandom());
    else if (pick < 95)
      send_request(OP_GET, hot_key(), $urandom());
    else
      send_request(OP_GET, $urandom(), $urandom());
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input logic [31:0] null_val);
    set_null_value(null_val);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_random_request();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_GET;
    key_i          = '0;
    new_value_i    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Null value still at its reset value here.
    send_request(OP_GET, 32'h0000_0000, 32'h0);
    send_request(OP_PUT, 32'h0000_0000, 32'h7fff_ffff);
    send_request(OP_GET, 32'h0000_0000, 32'h0);
    // Same bucket, keys differ only in the upper bits.
    send_request(OP_PUT, 32'h8000_0000, 32'h8000_0000);
    send_request(OP_PUT, 32'h0000_0400, 32'hffff_ffff);
    send_request(OP_GET, 32'h8000_0000, 32'h0);
    send_request(OP_GET, 32'h0000_0800, 32'hffff_ffff);
    send_request(OP_PUT, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h8000_0000, 32'h0);
    // Key -1 lands in the top bucket and 0xffff_fc00 in bucket 0: masking, not a modulo.
    send_request(OP_PUT, 32'hffff_ffff, 32'h1234_5678);
    send_request(OP_GET, 32'hffff_ffff, 32'h0);
    send_request(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(OP_GET, 32'h0000_03ff, 32'h0);
    send_request(OP_GET, 32'h7fff_ffff, 32'h0);
    send_request(OP_PUT, 32'hffff_fc00, 32'h0000_0001);
    send_request(OP_PUT, 32'h0000_0000, 32'haaaa_aaaa);
    send_request(OP_GET, 32'hffff_fc00, 32'h0);

    set_null_value(32'h8000_0000);
    send_request(OP_GET, 32'h5555_5555, 32'h0);
    send_request(OP_PUT, 32'h5555_5555, 32'h5555_5555);
    send_request(OP_GET, 32'h5555_5555, 32'h0);
    set_null_value(32'h7fff_ffff);
    send_request(OP_GET, 32'haaaa_aaaa, 32'h0);
    send_request(OP_PUT, 32'haaaa_aaaa, 32'h0);

    run_phase(0, 0, 32'hffff_ffff);
    run_phase(85, 0, 32'h8000_0000);
    run_phase(0, 85, 32'h7fff_ffff);
    run_phase(22, 22, $urandom());

    in_valid_i <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/chm_pkg.sv
rtl/chained_hash_map_int.sv
tb/chained_hash_map_int_test.sv
